/* sv/irt_pkg.sv */
// interval difficulty retarget: shared constants, word types and compact-target helpers
// no dependencies; imported by every module of the block
package irt_pkg;

    localparam int TARGET_BITS = 256;
    localparam int WORD_W      = 32;
    localparam int MANT_W      = 23;
    localparam int TS_W        = 31;
    localparam int SPAN_W      = TS_W + 2;
    localparam int PROD_W      = MANT_W + SPAN_W;
    localparam int SHIFT_W     = 11;
    localparam int BLEN_W      = 12;
    localparam int MANT_BYTES  = 3;

    // divider cell geometry
    localparam int STEP_BITS   = 8;
    localparam int CELL_BITS   = 32;
    localparam int PHASES      = CELL_BITS / STEP_BITS;
    localparam int PH_W        = $clog2(PHASES);
    localparam int NUM_CELLS   = (TARGET_BITS + CELL_BITS - 1) / CELL_BITS;
    localparam int DIV_BITS    = NUM_CELLS * CELL_BITS;

    // compact encoder geometry
    localparam int NUM_BYTES   = (TARGET_BITS + 7) / 8;
    localparam int BYTE_BITS   = NUM_BYTES * 8;
    localparam int SIZE_W      = $clog2(NUM_BYTES + 2);

    localparam int REG_IDX_W   = 2;
    typedef enum logic [REG_IDX_W-1:0] {
        REG_TIMESPAN    = 2'd0,
        REG_LIMIT       = 2'd1,
        REG_NO_RETARGET = 2'd2
    } t_reg;

    // decoded target: mantissa (already truncated to the target width) and bit shift
    typedef struct packed {
        logic [MANT_W-1:0]  mant;
        logic [SHIFT_W-1:0] shift;
    } t_dec;

    // dividend word leaving the front end
    typedef struct packed {
        logic                   valid;
        logic                   halve;
        logic [WORD_W-1:0]      pass;
        logic [TARGET_BITS-1:0] num;
    } t_front;

    // word held in each divider cell
    typedef struct packed {
        logic                valid;
        logic                halve;
        logic [WORD_W-1:0]   pass;
        logic [TS_W-1:0]     rem;
        logic [DIV_BITS-1:0] nq;
    } t_cell;

    // compact decode into mantissa and shift, bits beyond the target width dropped
    function automatic t_dec decode(input logic [WORD_W-1:0] c);
        logic [7:0]        e;
        logic [7:0]        ex;
        logic [MANT_W-1:0] m;
        t_dec              d;
        e       = c[31:24];
        m       = c[MANT_W-1:0];
        d.mant  = m;
        d.shift = '0;
        if (e <= 8'd3) begin
            ex     = 8'd3 - e;
            d.mant = m >> {ex[1:0], 3'b000};
        end else begin
            ex      = e - 8'd3;
            d.shift = {ex, 3'b000};
        end
        for (int i = 0; i < MANT_W; i++) begin
            if (int'(d.shift) + i >= TARGET_BITS) d.mant[i] = 1'b0;
        end
        return d;
    endfunction

    // bit length of a mantissa
    function automatic logic [4:0] mant_len(input logic [MANT_W-1:0] w);
        logic [4:0] len;
        len = '0;
        for (int i = 0; i < MANT_W; i++) begin
            if (w[i]) len = 5'(i + 1);
        end
        return len;
    endfunction

    // bit length of a decoded target
    function automatic logic [BLEN_W-1:0] dec_len(input t_dec d);
        logic [BLEN_W-1:0] len;
        if (d.mant == '0) len = '0;
        else len = BLEN_W'(d.shift) + BLEN_W'(mant_len(d.mant));
        return len;
    endfunction

    // full-width value of a decoded target
    function automatic logic [TARGET_BITS-1:0] widen(input t_dec d);
        logic [TARGET_BITS-1:0] v;
        v = TARGET_BITS'(d.mant) << d.shift;
        return v;
    endfunction

endpackage

/* sv/irt_front.sv */
// retarget front end: timespan clamp, target decode, halving, multiply, placement
// depends on irt_pkg; feeds the first divider cell
module irt_front import irt_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [WORD_W-1:0] i_prev,
    input  logic [WORD_W-1:0] i_last,
    input  logic [WORD_W-1:0] i_first,
    input  logic [TS_W-1:0]   i_ts,
    input  logic [BLEN_W-1:0] i_lb,
    input  logic              i_take,
    output t_front            o_word
);

    logic r_v1, r_v2, r_v3, r_v4;
    logic rdy2, rdy3, rdy4;

    logic [WORD_W-1:0] r_prev1, r_last1, r_first1;
    logic [MANT_W-1:0] r_mant2;
    logic [SHIFT_W-1:0] r_sh2, r_sh3;
    logic [SPAN_W-1:0] r_span2;
    logic r_h2, r_h3, r_h4;
    logic [WORD_W-1:0] r_pass2, r_pass3, r_pass4;
    logic [PROD_W-1:0] r_prod3;
    logic [TARGET_BITS-1:0] r_num4;

    t_dec               dec;
    logic [BLEN_W-1:0]  bt;
    logic               halve;
    logic signed [33:0] diff, lo, hi, span;
    logic [MANT_W-1:0]  n_mant;
    logic [SHIFT_W-1:0] n_sh;

    // ready chain through the four stages
    assign rdy4    = !r_v4 || i_take;
    assign rdy3    = !r_v3 || rdy4;
    assign rdy2    = !r_v2 || rdy3;
    assign o_ready = !r_v1 || rdy2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (o_ready) r_v1 <= i_valid;
            if (rdy2)    r_v2 <= r_v1;
            if (rdy3)    r_v3 <= r_v2;
            if (rdy4)    r_v4 <= r_v3;
        end
    end

    // input capture
    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_prev1  <= i_prev;
            r_last1  <= i_last;
            r_first1 <= i_first;
        end
    end

    // decode, clamp and halving decision
    always_comb begin
        dec   = decode(r_prev1);
        bt    = dec_len(dec);
        halve = (i_lb != '0) && (bt >= i_lb);
        diff  = $signed({2'b00, r_last1}) - $signed({2'b00, r_first1});
        lo    = $signed({5'b00000, i_ts[TS_W-1:2]});
        hi    = $signed({1'b0, i_ts, 2'b00});
        span  = diff;
        if (span < lo) span = lo;
        if (span > hi) span = hi;
        n_mant = dec.mant;
        n_sh   = dec.shift;
        if (halve) begin
            if (dec.shift != '0) n_sh = dec.shift - 1'b1;
            else n_mant = dec.mant >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy2) begin
            r_mant2 <= n_mant;
            r_sh2   <= n_sh;
            r_span2 <= span[SPAN_W-1:0];
            r_h2    <= halve;
            r_pass2 <= r_prev1;
        end
    end

    // mantissa times clamped span
    always_ff @(posedge i_clk) begin
        if (rdy3) begin
            r_prod3 <= PROD_W'(r_mant2) * PROD_W'(r_span2);
            r_sh3   <= r_sh2;
            r_h3    <= r_h2;
            r_pass3 <= r_pass2;
        end
    end

    // place the product at its bit position, top bits dropped
    always_ff @(posedge i_clk) begin
        if (rdy4) begin
            r_num4  <= TARGET_BITS'(r_prod3) << r_sh3;
            r_h4    <= r_h3;
            r_pass4 <= r_pass3;
        end
    end

    assign o_word = '{valid: r_v4, halve: r_h4, pass: r_pass4, num: r_num4};

endmodule

/* sv/irt_cell.sv */
// one divider cell: restoring division, eight quotient bits per cycle of load or step over a 32-bit slice
// depends on irt_pkg; chained by the top level
module irt_cell import irt_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  logic            i_step,
    input  logic [TS_W-1:0] i_ts,
    input  t_cell           i_prev,
    output t_cell           o_cur
);

    t_cell             r_cur;
    t_cell             n_cur;
    t_cell             src;
    logic [TS_W:0]     r2;
    logic              ge;

    // dividend shifts out at the top while quotient bits shift in at the bottom
    always_comb begin
        src   = i_load ? i_prev : r_cur;
        n_cur = src;
        r2    = '0;
        ge    = 1'b0;
        for (int s = 0; s < STEP_BITS; s++) begin
            r2 = {n_cur.rem, n_cur.nq[DIV_BITS-1]};
            ge = (r2 >= {1'b0, i_ts});
            if (ge) r2 = r2 - {1'b0, i_ts};
            n_cur.rem = r2[TS_W-1:0];
            n_cur.nq  = {n_cur.nq[DIV_BITS-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur.valid <= 1'b0;
        end else if (i_load || i_step) begin
            r_cur <= n_cur;
        end
    end

    assign o_cur = r_cur;

endmodule

/* sv/irt_tail.sv */
// retarget back end: doubling, cap at the limit, compact encode or pass-through, output register
// depends on irt_pkg; takes words from the last divider cell
module irt_tail import irt_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_load,
    input  t_cell                  i_cell,
    output logic                   o_ready,
    input  logic [TS_W-1:0]        i_ts,
    input  logic [TARGET_BITS-1:0] i_lim,
    input  logic                   i_nore,
    output logic                   o_tvalid,
    input  logic                   i_tready,
    output logic [WORD_W-1:0]      o_tdata
);

    logic r_v1, r_v2, r_v3;
    logic rdy2, rdy3;

    logic [TARGET_BITS-1:0] r_q1;
    logic [BYTE_BITS-1:0]   r_q2;
    logic [SIZE_W-1:0]      r_size2;
    logic [WORD_W-1:0]      r_pass1, r_pass2, r_data3;

    logic [TARGET_BITS-1:0] q;
    logic [BYTE_BITS-1:0]   qb;
    logic [SIZE_W-1:0]      size;
    logic [SIZE_W-1:0]      sz_dn;
    logic [1:0]             sz_up;
    logic [23:0]            m;
    logic [7:0]             sz_out;
    logic [WORD_W-1:0]      n_data;

    assign rdy3    = !r_v3 || i_tready;
    assign rdy2    = !r_v2 || rdy3;
    assign o_ready = !r_v1 || rdy2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (o_ready) r_v1 <= i_load && i_cell.valid;
            if (rdy2)    r_v2 <= r_v1;
            if (rdy3)    r_v3 <= r_v2;
        end
    end

    // quotient, doubling and cap
    always_comb begin
        q = i_cell.nq[TARGET_BITS-1:0];
        if (i_ts == '0) q = '0;
        if (i_cell.halve) q = q << 1;
        if (q > i_lim) q = i_lim;
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_q1    <= q;
            r_pass1 <= i_cell.pass;
        end
    end

    // byte length of the result
    always_comb begin
        qb   = BYTE_BITS'(r_q1);
        size = '0;
        for (int b = 0; b < NUM_BYTES; b++) begin
            if (|qb[b*8 +: 8]) size = SIZE_W'(b + 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy2) begin
            r_q2    <= qb;
            r_size2 <= size;
            r_pass2 <= r_pass1;
        end
    end

    // mantissa window and sign-bit adjustment
    always_comb begin
        sz_dn = '0;
        sz_up = '0;
        if (r_size2 <= SIZE_W'(MANT_BYTES)) begin
            sz_up = 2'(SIZE_W'(MANT_BYTES) - r_size2);
            m     = r_q2[23:0] << {sz_up, 3'b000};
        end else begin
            sz_dn = r_size2 - SIZE_W'(MANT_BYTES);
            m     = 24'(r_q2 >> {sz_dn, 3'b000});
        end
        sz_out = 8'(r_size2);
        if (m[23]) begin
            m      = m >> 8;
            sz_out = sz_out + 8'd1;
        end
        n_data = i_nore ? r_pass2 : {sz_out, 1'b0, m[MANT_W-1:0]};
    end

    always_ff @(posedge i_clk) begin
        if (rdy3) r_data3 <= n_data;
    end

    assign o_tvalid = r_v3;
    assign o_tdata  = r_data3;

endmodule

/* sv/interval_difficulty_retarget_unit.sv */
// interval difficulty retarget, top level: configuration registers, cell chain, stream ports
// depends on irt_pkg, irt_front, irt_cell, irt_tail
//
// Takes a word {first_time, last_time, prev_compact} and returns one compact target per
// word: elapsed time clamped to a quarter..four times the timespan, target scaled by
// clamped time over timespan (halved before and doubled after when near the limit),
// capped at the limit and re-encoded; with no_retarget set prev_compact is returned.
// The divider is a chain of 8 cells, each producing 8 quotient bits a cycle over its
// 32-bit slice while it loads or steps. The whole chain moves one cell at phase zero, when
// the last cell's word can be taken, and steps in place in the other phases, so a new word
// is accepted before the last one has left the divider; output stalls hold the chain.
// Configuration writes are registered and must be made while the block is idle.
module interval_difficulty_retarget_unit import irt_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    // prev_compact [31:0], last_time [63:32], first_time [95:64]
    input  logic [3*WORD_W-1:0]  i_s_tdata,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    // next_compact [31:0]
    output logic [WORD_W-1:0]    o_m_tdata,
    input  logic                 i_cfg_we,
    input  logic [REG_IDX_W-1:0] i_cfg_idx,
    input  logic [WORD_W-1:0]    i_cfg_wdata
);

    logic [TS_W-1:0]        r_ts;
    logic [WORD_W-1:0]      r_limc;
    logic                   r_nore;
    logic [TARGET_BITS-1:0] r_lim;
    logic [BLEN_W-1:0]      r_lb;
    logic [PH_W-1:0]        r_ph;

    logic   adv;
    logic   tail_ready;
    t_front fw;
    t_cell  w_cell [NUM_CELLS+1];

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ts   <= TS_W'(302400);
            r_limc <= 32'h1e0f_ffff;
            r_nore <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_TIMESPAN:    r_ts   <= i_cfg_wdata[TS_W-1:0];
                REG_LIMIT:       r_limc <= i_cfg_wdata;
                REG_NO_RETARGET: r_nore <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // decoded limit and its bit length
    always_ff @(posedge i_clk) begin
        r_lim <= widen(decode(r_limc));
        r_lb  <= dec_len(decode(r_limc));
    end

    // chain phase: move at phase zero, then three in-place steps
    assign adv = (r_ph == '0) && (!w_cell[NUM_CELLS].valid || tail_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ph <= '0;
        else if (adv || r_ph != '0) r_ph <= r_ph + 1'b1;
    end

    irt_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_prev  (i_s_tdata[WORD_W-1:0]),
        .i_last  (i_s_tdata[2*WORD_W-1:WORD_W]),
        .i_first (i_s_tdata[3*WORD_W-1:2*WORD_W]),
        .i_ts    (r_ts),
        .i_lb    (r_lb),
        .i_take  (adv),
        .o_word  (fw)
    );

    assign w_cell[0] = '{valid: fw.valid, halve: fw.halve, pass: fw.pass,
                         rem: '0, nq: DIV_BITS'(fw.num)};

    // divider chain
    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        irt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_load  (adv),
            .i_step  (r_ph != '0),
            .i_ts    (r_ts),
            .i_prev  (w_cell[g]),
            .o_cur   (w_cell[g+1])
        );
    end

    irt_tail u_tail (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (adv),
        .i_cell   (w_cell[NUM_CELLS]),
        .o_ready  (tail_ready),
        .i_ts     (r_ts),
        .i_lim    (r_lim),
        .i_nore   (r_nore),
        .o_tvalid (o_m_tvalid),
        .i_tready (i_m_tready),
        .o_tdata  (o_m_tdata)
    );

endmodule

/* tb/sv/interval_difficulty_retarget_unit_check.sv */
// interval difficulty retarget: checker that snoops the stream and configuration ports
// depends on irt_pkg; predicts every compact target and compares it with the block output
`timescale 1ns / 100ps

module interval_difficulty_retarget_unit_check import irt_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    input  logic                 i_s_tready,
    input  logic [3*WORD_W-1:0]  i_s_tdata,
    input  logic                 i_m_tvalid,
    input  logic                 i_m_tready,
    input  logic [WORD_W-1:0]    i_m_tdata,
    input  logic                 i_cfg_we,
    input  logic [REG_IDX_W-1:0] i_cfg_idx,
    input  logic [WORD_W-1:0]    i_cfg_wdata,
    output int                   o_fail_count,
    output int                   o_pending
);

    typedef logic [TARGET_BITS-1:0] t_wide;

    // shadow copy of the configuration registers
    logic [TS_W-1:0]   timespan_q;
    logic [WORD_W-1:0] limit_q;
    logic              hold_q;

    logic [WORD_W-1:0] target_queue[$];
    int                fails;

    assign o_fail_count = fails;
    assign o_pending    = target_queue.size();

    // compact form to full-width target, overflowing bits lost
    function automatic t_wide unpack_compact(input logic [WORD_W-1:0] c);
        logic [7:0]        e;
        logic [MANT_W-1:0] m;
        e = c[31:24];
        m = c[MANT_W-1:0];
        if (e <= 8'd3) return t_wide'(m >> (8 * (3 - e)));
        return t_wide'(m) << (8 * (int'(e) - 3));
    endfunction

    function automatic int width_of(input t_wide v);
        for (int i = TARGET_BITS - 1; i >= 0; i--) begin
            if (v[i]) return i + 1;
        end
        return 0;
    endfunction

    function automatic logic [WORD_W-1:0] pack_compact(input t_wide v);
        int          size;
        logic [31:0] m;
        t_wide       sh;
        size = (width_of(v) + 7) / 8;
        if (size <= 3) begin
            m = v[31:0] << (8 * (3 - size));
        end else begin
            sh = v >> (8 * (size - 3));
            m  = sh[31:0] & 32'h00ff_ffff;
        end
        if (m[23]) begin
            m    = m >> 8;
            size = size + 1;
        end
        return {8'(size), 1'b0, m[22:0]};
    endfunction

    // next compact target for one word under the current settings
    function automatic logic [WORD_W-1:0] retarget(input logic [3*WORD_W-1:0] w);
        logic [WORD_W-1:0] prev;
        longint            span;
        longint            lo;
        longint            hi;
        t_wide             tgt;
        t_wide             lim;
        int                lim_len;
        logic              halve;
        prev = w[31:0];
        if (hold_q) return prev;
        span = longint'(w[63:32]) - longint'(w[95:64]);
        lo   = longint'(timespan_q) / 4;
        hi   = longint'(timespan_q) * 4;
        if (span < lo) span = lo;
        if (span > hi) span = hi;
        tgt     = unpack_compact(prev);
        lim     = unpack_compact(limit_q);
        lim_len = width_of(lim);
        halve   = (lim_len != 0) && (width_of(tgt) > lim_len - 1);
        if (halve) tgt = tgt >> 1;
        tgt = tgt * t_wide'(span);
        if (timespan_q != '0) tgt = tgt / t_wide'(timespan_q);
        else tgt = '0;
        if (halve) tgt = tgt << 1;
        if (tgt > lim) tgt = lim;
        return pack_compact(tgt);
    endfunction

    task automatic report(input string what, input logic [WORD_W-1:0] got,
                          input logic [WORD_W-1:0] want);
        $display("%0t mismatch: %s got %08h want %08h", $realtime, what, got, want);
        fails++;
    endtask

    // configuration snoop, prediction on accept, compare on output
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            timespan_q = 31'd302400;
            limit_q    = 32'h1e0f_ffff;
            hold_q     = 1'b0;
            target_queue.delete();
            fails      = 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (target_queue.size() == 0)
                    report("unexpected word", i_m_tdata, '0);
                else if (i_m_tdata !== target_queue[0])
                    report("next_compact", i_m_tdata, target_queue.pop_front());
                else
                    void'(target_queue.pop_front());
            end
            if (i_s_tvalid && i_s_tready) target_queue.push_back(retarget(i_s_tdata));
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_TIMESPAN:    timespan_q = i_cfg_wdata[TS_W-1:0];
                    REG_LIMIT:       limit_q    = i_cfg_wdata;
                    REG_NO_RETARGET: hold_q     = i_cfg_wdata[0];
                    default: ;
                endcase
            end
        end
    end

endmodule

/* tb/sv/interval_difficulty_retarget_unit_test.sv */
// interval difficulty retarget: testbench top, clock, reset, stimulus and verdict
// depends on irt_pkg, interval_difficulty_retarget_unit and its checker module
`timescale 1ns / 100ps

module interval_difficulty_retarget_unit_test;
    import irt_pkg::*;

    localparam int CYCLE_LIMIT = 800000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [3*WORD_W-1:0]  s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [WORD_W-1:0]    m_tdata;
    logic                 cfg_we = 1'b0;
    logic [REG_IDX_W-1:0] cfg_idx = REG_TIMESPAN;
    logic [WORD_W-1:0]    cfg_wdata = '0;
    int                   fail_count;
    int                   pending;
    int                   cycles = 0;
    int                   burst_left = 0;
    logic [TS_W-1:0]      cur_timespan = 31'd302400;

    always #4 i_clk = ~i_clk;

    interval_difficulty_retarget_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .o_s_tready(s_tready), .i_s_tdata(s_tdata),
        .o_m_tvalid(m_tvalid), .i_m_tready(m_tready), .o_m_tdata(m_tdata),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_wdata(cfg_wdata)
    );

    interval_difficulty_retarget_unit_check checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready), .i_s_tdata(s_tdata),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready), .i_m_tdata(m_tdata),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_wdata(cfg_wdata),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("interval_difficulty_retarget_unit test failed");
            $finish;
        end
    end

    // receiver stall pattern: free-running, coin toss, or long stalls
    int ready_mode = 0;
    int mode_left  = 0;
    always @(posedge i_clk) begin
        if (mode_left == 0) begin
            ready_mode <= $urandom_range(0, 2);
            mode_left  <= $urandom_range(50, 300);
        end else begin
            mode_left <= mode_left - 1;
        end
        case (ready_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= $urandom_range(0, 1);
            default: m_tready <= ($urandom_range(0, 9) == 0);
        endcase
    end

    // one word, inside bursts of random length with random gaps between them
    task automatic send_word(input logic [WORD_W-1:0] prev, input logic [WORD_W-1:0] last_t,
                             input logic [WORD_W-1:0] first_t);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {first_t, last_t, prev};
        do @(posedge i_clk); while (!s_tready);
    endtask

    // one register write, then the write strobe is held low so back-to-back writes stay apart
    task automatic write_reg(input t_reg idx, input logic [WORD_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        if (idx == REG_TIMESPAN) cur_timespan = val[TS_W-1:0];
        @(posedge i_clk);
    endtask

    // let every expected word drain before touching the registers
    task automatic settle();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // mostly plausible intervals around the timespan, some pure noise
    task automatic random_words(input int n);
        logic [WORD_W-1:0] prev;
        logic [WORD_W-1:0] first_t;
        longint            dt;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 4) == 0) begin
                send_word($urandom, $urandom, $urandom);
            end else begin
                prev    = {8'($urandom_range(0, 34)), 24'($urandom)};
                first_t = $urandom;
                dt = (longint'(cur_timespan) * $urandom_range(0, 600)) / 100;
                if ($urandom_range(0, 7) == 0) dt = -longint'($urandom_range(0, 1000));
                send_word(prev, 32'(longint'(first_t) + dt), first_t);
            end
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: exponent extremes, sign bit, clamps, backwards time, near-limit halving
        send_word(32'h1d00_ffff, 32'd1_302_400, 32'd1_000_000);
        send_word(32'h1e0f_ffff, 32'd302_400, 32'd0);
        send_word(32'h1e0f_ffff, 32'hffff_ffff, 32'd0);
        send_word(32'h1c7f_ffff, 32'd0, 32'hffff_ffff);
        send_word(32'h0000_0000, 32'd0, 32'd0);
        send_word(32'h017f_ffff, 32'd5, 32'd5);
        send_word(32'h0212_3456, 32'd1_000_000, 32'd10);
        send_word(32'h0312_3456, 32'd10, 32'd1_000_000);
        send_word(32'h04ff_ffff, 32'd600_000, 32'd0);
        send_word(32'hff7f_ffff, 32'd302_400, 32'd0);
        send_word(32'h2112_3456, 32'd302_400, 32'd0);
        send_word(32'h2080_0001, 32'd1_209_600, 32'd0);
        send_word(32'h1d80_0000, 32'd75_600, 32'd0);
        send_word(32'h1e07_ffff, 32'd2_000_000, 32'd0);
        send_word(32'h1e08_0000, 32'd604_800, 32'd0);
        send_word(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        random_words(180);

        settle();
        write_reg(REG_TIMESPAN, 32'd4);
        random_words(180);

        settle();
        write_reg(REG_TIMESPAN, 32'h7fff_ffff);
        write_reg(REG_LIMIT, 32'hffff_ffff);
        send_word(32'h2080_0000, 32'hffff_ffff, 32'd0);
        send_word(32'h207f_ffff, 32'd0, 32'hffff_ffff);
        random_words(180);

        settle();
        write_reg(REG_TIMESPAN, 32'd0);
        write_reg(REG_LIMIT, 32'd0);
        random_words(60);

        settle();
        write_reg(REG_TIMESPAN, 32'd3);
        write_reg(REG_LIMIT, 32'h2100_ffff);
        random_words(120);

        settle();
        write_reg(REG_NO_RETARGET, 32'd1);
        random_words(120);

        settle();
        write_reg(REG_NO_RETARGET, 32'd0);
        write_reg(REG_TIMESPAN, 32'd600);
        write_reg(REG_LIMIT, 32'h0412_3456);
        random_words(180);

        settle();
        write_reg(REG_TIMESPAN, 32'd302_400);
        write_reg(REG_LIMIT, 32'h1e0f_ffff);
        random_words(200);

        settle();
        repeat (50) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("interval_difficulty_retarget_unit test passed");
        else
            $display("interval_difficulty_retarget_unit test failed");
        $finish;
    end

endmodule
